// ----- rtl/reb_pkg.sv -----
`timescale 1ns / 1ps

package reb_pkg;

  localparam int unsigned COUNT_WIDTH = 16;

  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PUSH_W  = 16;
  localparam int unsigned DELTA_W = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PUSH_W-1:0] SHORT_PUSH_RST = 16'd50;
  localparam logic [PUSH_W-1:0] LONG_PUSH_RST  = 16'd1000;

  typedef enum logic [2:0] {
    OP_SAMPLE      = 3'd0,
    OP_READ_DELTA  = 3'd1,
    OP_POLL_OK     = 3'd2,
    OP_POLL_CANCEL = 3'd3,
    OP_SET_COUNT   = 3'd4,
    OP_CLEAR_COUNT = 3'd5,
    OP_CLEAR_ENTER = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENCODER_KIND = 3'd0,
    CFG_ACTIVE_LOW   = 3'd1,
    CFG_COUNT_MIN    = 3'd2,
    CFG_COUNT_MAX    = 3'd3,
    CFG_WRAP_ENABLE  = 3'd4,
    CFG_SHORT_PUSH   = 3'd5,
    CFG_LONG_PUSH    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PRESS_IDLE   = 2'd0,
    PRESS_OK     = 2'd1,
    PRESS_CANCEL = 2'd2,
    PRESS_HELD   = 2'd3
  } press_e;

  typedef struct packed {
    logic              fire;
    logic [2:0]        op;
    logic              pin_enter;
    logic [TIME_W-1:0] now_ms;
  } btn_req_t;

  typedef struct packed {
    logic              active_low;
    logic [PUSH_W-1:0] short_push_ms;
    logic [PUSH_W-1:0] long_push_ms;
  } btn_cfg_t;

  typedef struct packed {
    logic   ok_seen;
    logic   cancel_seen;
    press_e state;
  } btn_rsp_t;

endpackage

// ----- rtl/reb_button.sv -----
`timescale 1ns / 1ps

module reb_button (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  reb_pkg::btn_req_t req_i,
  input  reb_pkg::btn_cfg_t cfg_i,
  output reb_pkg::btn_rsp_t rsp_o
);

  reb_pkg::press_e                 state_q, state_d;
  logic [reb_pkg::TIME_W-1:0]      start_q, start_d;
  logic                            prev_enter_q, prev_enter_d;
  logic                            held;
  logic [reb_pkg::TIME_W-1:0]      held_for;
  logic                            past_long;
  logic                            past_short;
  logic                            ok_d;
  logic                            cancel_d;

  assign held       = req_i.pin_enter ^ cfg_i.active_low;
  assign held_for   = req_i.now_ms - start_q;
  assign past_long  = held_for > {16'd0, cfg_i.long_push_ms};
  assign past_short = held_for > {16'd0, cfg_i.short_push_ms};

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    prev_enter_d = prev_enter_q;
    ok_d         = 1'b0;
    cancel_d     = 1'b0;
    case (reb_pkg::op_e'(req_i.op))
      reb_pkg::OP_SAMPLE: begin
        if (req_i.pin_enter != prev_enter_q) begin
          if (held) begin
            start_d = req_i.now_ms;
          end else if (state_q == reb_pkg::PRESS_HELD) begin
            // Cancel was already reported while held, so the release is silent.
            state_d = reb_pkg::PRESS_IDLE;
          end else if (past_long) begin
            state_d = reb_pkg::PRESS_CANCEL;
          end else if (past_short) begin
            state_d = reb_pkg::PRESS_OK;
          end
        end
        prev_enter_d = req_i.pin_enter;
      end
      reb_pkg::OP_POLL_OK: begin
        if (state_q == reb_pkg::PRESS_OK) begin
          ok_d    = 1'b1;
          state_d = reb_pkg::PRESS_IDLE;
        end
      end
      reb_pkg::OP_POLL_CANCEL: begin
        if (state_q == reb_pkg::PRESS_CANCEL) begin
          cancel_d = 1'b1;
          state_d  = reb_pkg::PRESS_IDLE;
        end else if (state_q != reb_pkg::PRESS_HELD && held && past_long) begin
          cancel_d = 1'b1;
          state_d  = reb_pkg::PRESS_HELD;
        end
      end
      reb_pkg::OP_CLEAR_ENTER: begin
        state_d = reb_pkg::PRESS_IDLE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= reb_pkg::PRESS_IDLE;
      start_q      <= '0;
      prev_enter_q <= 1'b0;
    end else if (req_i.fire) begin
      state_q      <= state_d;
      start_q      <= start_d;
      prev_enter_q <= prev_enter_d;
    end
  end

  assign rsp_o.ok_seen     = ok_d;
  assign rsp_o.cancel_seen = cancel_d;
  assign rsp_o.state       = state_d;

endmodule

// ----- rtl/rotary_encoder_with_push_button.sv -----
`timescale 1ns / 1ps
// A request is accepted into the input register and moves into the result register when
// that register is free or being drained; the count and button state update at that move.
// Throughput: one request per clock while results are drained without a stall.
// Reset: configuration returns to its defaults (short push 50 ms, long push 1000 ms,
// all else zero), and the count, last read count and button state clear to zero.

module rotary_encoder_with_push_button #(
  parameter int unsigned COUNT_WIDTH = reb_pkg::COUNT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          operation_i,
  input  logic                                pin_a_i,
  input  logic                                pin_b_i,
  input  logic                                pin_enter_i,
  input  logic [reb_pkg::TIME_W-1:0]          now_ms_i,
  input  logic signed [reb_pkg::LIMIT_W-1:0]  new_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COUNT_WIDTH-1:0]       count_now_o,
  output logic signed [reb_pkg::DELTA_W-1:0]  delta_o,
  output logic                                changed_o,
  output logic                                ok_seen_o,
  output logic                                cancel_seen_o,
  output logic [1:0]                          button_state_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [reb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [reb_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // Configuration registers
  logic                               kind_q;
  logic                               active_low_q;
  logic signed [reb_pkg::LIMIT_W-1:0] count_min_q;
  logic signed [reb_pkg::LIMIT_W-1:0] count_max_q;
  logic                               wrap_q;
  logic [reb_pkg::PUSH_W-1:0]         short_push_q;
  logic [reb_pkg::PUSH_W-1:0]         long_push_q;

  // Input register
  logic                               in_valid_q;
  logic [2:0]                         op_q;
  logic                               pin_a_q;
  logic                               pin_b_q;
  logic                               pin_enter_q;
  logic [reb_pkg::TIME_W-1:0]         now_q;
  logic signed [reb_pkg::LIMIT_W-1:0] new_count_q;

  // Encoder state
  logic signed [COUNT_WIDTH-1:0]      count_q, count_d;
  logic signed [COUNT_WIDTH-1:0]      last_read_q, last_read_d;
  logic                               prev_a_q, prev_a_d;

  logic                               advance;
  logic                               step;
  logic                               step_up;
  logic signed [32:0]                 count_x;
  logic signed [32:0]                 last_x;
  logic signed [32:0]                 min_x;
  logic signed [32:0]                 max_x;
  logic signed [32:0]                 new_x;
  logic signed [32:0]                 diff_x;
  logic signed [COUNT_WIDTH-1:0]      min_c;
  logic signed [COUNT_WIDTH-1:0]      max_c;
  logic signed [COUNT_WIDTH-1:0]      stepped;
  logic signed [reb_pkg::DELTA_W-1:0] delta_d;
  logic                               changed_d;

  reb_pkg::btn_req_t                  btn_req;
  reb_pkg::btn_cfg_t                  btn_cfg;
  reb_pkg::btn_rsp_t                  btn_rsp;

  // Result register
  logic                               out_valid_q;
  logic signed [COUNT_WIDTH-1:0]      res_count_q;
  logic signed [reb_pkg::DELTA_W-1:0] res_delta_q;
  logic                               res_changed_q;
  logic                               res_ok_q;
  logic                               res_cancel_q;
  reb_pkg::press_e                    res_state_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= 1'b0;
      active_low_q <= 1'b0;
      count_min_q  <= '0;
      count_max_q  <= '0;
      wrap_q       <= 1'b0;
      short_push_q <= reb_pkg::SHORT_PUSH_RST;
      long_push_q  <= reb_pkg::LONG_PUSH_RST;
    end else if (cfg_valid_i) begin
      case (reb_pkg::cfg_idx_e'(cfg_index_i))
        reb_pkg::CFG_ENCODER_KIND: kind_q       <= cfg_data_i[0];
        reb_pkg::CFG_ACTIVE_LOW:   active_low_q <= cfg_data_i[0];
        reb_pkg::CFG_COUNT_MIN:    count_min_q  <= cfg_data_i;
        reb_pkg::CFG_COUNT_MAX:    count_max_q  <= cfg_data_i;
        reb_pkg::CFG_WRAP_ENABLE:  wrap_q       <= cfg_data_i[0];
        reb_pkg::CFG_SHORT_PUSH:   short_push_q <= cfg_data_i;
        reb_pkg::CFG_LONG_PUSH:    long_push_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q        <= operation_i;
      pin_a_q     <= pin_a_i;
      pin_b_q     <= pin_b_i;
      pin_enter_q <= pin_enter_i;
      now_q       <= now_ms_i;
      new_count_q <= new_count_i;
    end
  end

  // Limits and loaded values are compared in a width that holds every count.
  assign count_x = 33'(count_q);
  assign last_x  = 33'(last_read_q);
  assign min_x   = 33'(count_min_q);
  assign max_x   = 33'(count_max_q);
  assign new_x   = 33'(new_count_q);
  assign diff_x  = count_x - last_x;
  assign min_c   = min_x[COUNT_WIDTH-1:0];
  assign max_c   = max_x[COUNT_WIDTH-1:0];

  always_comb begin
    if (kind_q) begin
      step    = pin_a_q && !prev_a_q;
      step_up = !pin_b_q;
    end else begin
      step    = pin_a_q != prev_a_q;
      step_up = pin_a_q != pin_b_q;
    end
    if (step_up) begin
      if (count_x < max_x) begin
        stepped = count_q + COUNT_WIDTH'(1);
      end else begin
        stepped = wrap_q ? min_c : max_c;
      end
    end else begin
      if (count_x > min_x) begin
        stepped = count_q - COUNT_WIDTH'(1);
      end else begin
        stepped = wrap_q ? max_c : min_c;
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    last_read_d = last_read_q;
    prev_a_d    = prev_a_q;
    delta_d     = '0;
    changed_d   = 1'b0;
    case (reb_pkg::op_e'(op_q))
      reb_pkg::OP_SAMPLE: begin
        if (step) begin
          count_d = stepped;
        end
        prev_a_d = pin_a_q;
      end
      reb_pkg::OP_READ_DELTA: begin
        delta_d     = diff_x[reb_pkg::DELTA_W-1:0];
        changed_d   = diff_x != '0;
        last_read_d = count_q;
      end
      reb_pkg::OP_SET_COUNT: begin
        count_d     = new_x[COUNT_WIDTH-1:0];
        last_read_d = new_x[COUNT_WIDTH-1:0];
      end
      reb_pkg::OP_CLEAR_COUNT: begin
        count_d = min_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_read_q <= '0;
      prev_a_q    <= 1'b0;
    end else if (advance) begin
      count_q     <= count_d;
      last_read_q <= last_read_d;
      prev_a_q    <= prev_a_d;
    end
  end

  assign btn_req.fire          = advance;
  assign btn_req.op            = op_q;
  assign btn_req.pin_enter     = pin_enter_q;
  assign btn_req.now_ms        = now_q;
  assign btn_cfg.active_low    = active_low_q;
  assign btn_cfg.short_push_ms = short_push_q;
  assign btn_cfg.long_push_ms  = long_push_q;

  reb_button u_button (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (btn_req),
    .cfg_i  (btn_cfg),
    .rsp_o  (btn_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_count_q   <= count_d;
      res_delta_q   <= delta_d;
      res_changed_q <= changed_d;
      res_ok_q      <= btn_rsp.ok_seen;
      res_cancel_q  <= btn_rsp.cancel_seen;
      res_state_q   <= btn_rsp.state;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign count_now_o    = res_count_q;
  assign delta_o        = res_delta_q;
  assign changed_o      = res_changed_q;
  assign ok_seen_o      = res_ok_q;
  assign cancel_seen_o  = res_cancel_q;
  assign button_state_o = res_state_q;

  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("accepted request did not produce a result");

  a_ok_cancel_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(ok_seen_o && cancel_seen_o))
    else $error("ok and cancel reported by the same request");

  a_ok_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ok_seen_o) |-> (button_state_o == reb_pkg::PRESS_IDLE))
    else $error("ok reported without returning to idle");

  a_cancel_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cancel_seen_o) |->
      (button_state_o == reb_pkg::PRESS_IDLE || button_state_o == reb_pkg::PRESS_HELD))
    else $error("cancel reported with an inconsistent button state");

endmodule

// ----- test/rotary_encoder_with_push_button_tb.sv -----
`timescale 1ns / 1ps

module rotary_encoder_with_push_button_tb;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]                         op;
    logic                               a;
    logic                               b;
    logic                               e;
    logic [reb_pkg::TIME_W-1:0]         now;
    logic signed [reb_pkg::LIMIT_W-1:0] nc;
  } request_t;

  typedef struct packed {
    logic signed [reb_pkg::COUNT_WIDTH-1:0] count;
    logic signed [reb_pkg::DELTA_W-1:0]     delta;
    logic                                   changed;
    logic                                   ok;
    logic                                   cancel;
    reb_pkg::press_e                        state;
  } readout_t;

  logic                                   clk_i;
  logic                                   rst_ni = 1'b0;
  logic                                   in_valid_i = 1'b0;
  logic                                   in_ready_o;
  logic [2:0]                             operation_i = '0;
  logic                                   pin_a_i = 1'b0;
  logic                                   pin_b_i = 1'b0;
  logic                                   pin_enter_i = 1'b0;
  logic [reb_pkg::TIME_W-1:0]             now_ms_i = '0;
  logic signed [reb_pkg::LIMIT_W-1:0]     new_count_i = '0;
  logic                                   out_valid_o;
  logic                                   out_ready_i = 1'b0;
  logic signed [reb_pkg::COUNT_WIDTH-1:0] count_now_o;
  logic signed [reb_pkg::DELTA_W-1:0]     delta_o;
  logic                                   changed_o;
  logic                                   ok_seen_o;
  logic                                   cancel_seen_o;
  logic [1:0]                             button_state_o;
  logic                                   cfg_valid_i = 1'b0;
  logic                                   cfg_ready_o;
  logic [reb_pkg::CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [reb_pkg::CFG_DATA_W-1:0]         cfg_data_i = '0;

  rotary_encoder_with_push_button dut (.*);

  // Predictor copy of the configuration and state.
  logic                                   kind_cui, act_low, wrap_on;
  logic signed [reb_pkg::LIMIT_W-1:0]     cnt_min, cnt_max;
  logic [reb_pkg::PUSH_W-1:0]             short_ms, long_ms;
  logic signed [reb_pkg::COUNT_WIDTH-1:0] enc_count, enc_last_read;
  reb_pkg::press_e                        btn_state;
  logic [reb_pkg::TIME_W-1:0]             btn_t0;
  logic                                   last_a, last_enter;

  request_t pending_requests[$];
  readout_t expected_readouts[$];
  int       items_pushed = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       settings_count = 0;
  logic     in_taken = 1'b0;
  logic     no_idle = 1'b0;

  // Generator view of the pins and of the millisecond clock.
  logic                       cur_a = 1'b0, cur_b = 1'b0, cur_e = 1'b0;
  logic [reb_pkg::TIME_W-1:0] gen_ms = '0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void count_up();
    if (enc_count < cnt_max) enc_count = enc_count + reb_pkg::COUNT_WIDTH'(1);
    else enc_count = wrap_on ? cnt_min : cnt_max;
  endfunction

  function automatic void count_down();
    if (enc_count > cnt_min) enc_count = enc_count - reb_pkg::COUNT_WIDTH'(1);
    else enc_count = wrap_on ? cnt_max : cnt_min;
  endfunction

  function automatic logic held_for(logic [reb_pkg::TIME_W-1:0] now,
                                    logic [reb_pkg::PUSH_W-1:0] lim);
    logic [reb_pkg::TIME_W-1:0] span;
    span = now - btn_t0;
    return span > reb_pkg::TIME_W'(lim);
  endfunction

  function automatic readout_t encoder_step(request_t rq);
    readout_t r;
    r = '0;
    case (rq.op)
      reb_pkg::OP_SAMPLE: begin
        if (!kind_cui) begin
          if (rq.a != last_a) begin
            if (rq.a == rq.b) count_down();
            else count_up();
          end
        end else if (rq.a && !last_a) begin
          if (!rq.b) count_up();
          else count_down();
        end
        if (rq.e != last_enter) begin
          if (rq.e ^ act_low) btn_t0 = rq.now;
          else if (btn_state == reb_pkg::PRESS_HELD) btn_state = reb_pkg::PRESS_IDLE;
          else if (held_for(rq.now, long_ms)) btn_state = reb_pkg::PRESS_CANCEL;
          else if (held_for(rq.now, short_ms)) btn_state = reb_pkg::PRESS_OK;
        end
        last_a = rq.a;
        last_enter = rq.e;
      end
      reb_pkg::OP_READ_DELTA: begin
        r.delta = {enc_count[reb_pkg::COUNT_WIDTH-1], enc_count}
                  - {enc_last_read[reb_pkg::COUNT_WIDTH-1], enc_last_read};
        r.changed = (enc_count != enc_last_read);
        enc_last_read = enc_count;
      end
      reb_pkg::OP_POLL_OK: begin
        if (btn_state == reb_pkg::PRESS_OK) begin
          r.ok = 1'b1;
          btn_state = reb_pkg::PRESS_IDLE;
        end
      end
      reb_pkg::OP_POLL_CANCEL: begin
        // A cancel already reported while held stays silent until release.
        if (btn_state == reb_pkg::PRESS_CANCEL) begin
          r.cancel = 1'b1;
          btn_state = reb_pkg::PRESS_IDLE;
        end else if (btn_state != reb_pkg::PRESS_HELD && (rq.e ^ act_low)
                     && held_for(rq.now, long_ms)) begin
          r.cancel = 1'b1;
          btn_state = reb_pkg::PRESS_HELD;
        end
      end
      reb_pkg::OP_SET_COUNT: begin
        enc_count = rq.nc;
        enc_last_read = rq.nc;
      end
      reb_pkg::OP_CLEAR_COUNT: enc_count = cnt_min;
      reb_pkg::OP_CLEAR_ENTER: btn_state = reb_pkg::PRESS_IDLE;
      default: ;
    endcase
    r.count = enc_count;
    r.state = btn_state;
    return r;
  endfunction

  function automatic void apply_reg(reb_pkg::cfg_idx_e idx,
                                    logic [reb_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      reb_pkg::CFG_ENCODER_KIND: kind_cui = d[0];
      reb_pkg::CFG_ACTIVE_LOW:   act_low = d[0];
      reb_pkg::CFG_COUNT_MIN:    cnt_min = d;
      reb_pkg::CFG_COUNT_MAX:    cnt_max = d;
      reb_pkg::CFG_WRAP_ENABLE:  wrap_on = d[0];
      reb_pkg::CFG_SHORT_PUSH:   short_ms = d;
      reb_pkg::CFG_LONG_PUSH:    long_ms = d;
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: inputs change on the falling edge only.
  always @(negedge clk_i) begin : drive_requests
    request_t rq;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_requests.size() > 0 && (no_idle || $urandom_range(0, 99) >= 11)) begin
        rq = pending_requests.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= rq.op;
        pin_a_i     <= rq.a;
        pin_b_i     <= rq.b;
        pin_enter_i <= rq.e;
        now_ms_i    <= rq.now;
        new_count_i <= rq.nc;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_ready
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 11);
  end

  // Checks each result first, then predicts the request accepted at this edge.
  always @(posedge clk_i) begin : watch_results
    request_t rq;
    readout_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (expected_readouts.size() == 0) begin
          $error("result with no request outstanding: count_now %0d", count_now_o);
          mismatches++;
        end else begin
          want = expected_readouts.pop_front();
          check_field("count_now", want.count, count_now_o);
          check_field("delta", want.delta, delta_o);
          check_field("changed", want.changed, changed_o);
          check_field("ok_seen", want.ok, ok_seen_o);
          check_field("cancel_seen", want.cancel, cancel_seen_o);
          check_field("button_state", want.state, button_state_o);
        end
      end
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        rq.op  = operation_i;
        rq.a   = pin_a_i;
        rq.b   = pin_b_i;
        rq.e   = pin_enter_i;
        rq.now = now_ms_i;
        rq.nc  = new_count_i;
        expected_readouts.push_back(encoder_step(rq));
      end
    end
  end

  task automatic add_req(input logic [2:0] op, input logic a, input logic b, input logic e,
                         input logic [reb_pkg::TIME_W-1:0] now,
                         input logic signed [reb_pkg::LIMIT_W-1:0] nc);
    request_t rq;
    rq.op  = op;
    rq.a   = a;
    rq.b   = b;
    rq.e   = e;
    rq.now = now;
    rq.nc  = nc;
    pending_requests.push_back(rq);
    items_pushed++;
    if (op == reb_pkg::OP_SAMPLE) begin
      cur_a = a;
      cur_b = b;
      cur_e = e;
    end
  endtask

  task automatic drain();
    while (results_seen < items_pushed) @(negedge clk_i);
  endtask

  task automatic write_reg(input reb_pkg::cfg_idx_e idx,
                           input logic [reb_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_all(input logic k, input logic al, input logic [15:0] lo,
                         input logic [15:0] hi, input logic w, input logic [15:0] sh,
                         input logic [15:0] lg);
    drain();
    write_reg(reb_pkg::CFG_ENCODER_KIND, reb_pkg::CFG_DATA_W'(k));
    write_reg(reb_pkg::CFG_ACTIVE_LOW, reb_pkg::CFG_DATA_W'(al));
    write_reg(reb_pkg::CFG_COUNT_MIN, lo);
    write_reg(reb_pkg::CFG_COUNT_MAX, hi);
    write_reg(reb_pkg::CFG_WRAP_ENABLE, reb_pkg::CFG_DATA_W'(w));
    write_reg(reb_pkg::CFG_SHORT_PUSH, sh);
    write_reg(reb_pkg::CFG_LONG_PUSH, lg);
    settings_count++;
  endtask

  function automatic logic signed [reb_pkg::LIMIT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return cnt_min;
      1: return cnt_max;
      2: return 16'sh7FFF;
      3: return 16'sh8000;
      default: return reb_pkg::LIMIT_W'($urandom);
    endcase
  endfunction

  // Legal quadrature steps: one pin toggles per sample, in one direction.
  task automatic rotate_run();
    int   len;
    logic cw;
    len = $urandom_range(1, 16);
    cw  = 1'($urandom_range(0, 1));
    repeat (len) begin
      if ((cur_a == cur_b) == cw) cur_b = ~cur_b;
      else cur_a = ~cur_a;
      gen_ms += $urandom_range(0, 3);
      add_req(reb_pkg::OP_SAMPLE, cur_a, cur_b, cur_e, gen_ms, pick_count());
    end
  endtask

  task automatic push_button();
    logic                       down;
    int                         hold, base, steps;
    logic [reb_pkg::TIME_W-1:0] t0;
    down = ~act_low;
    if (cur_e == down) begin
      gen_ms += $urandom_range(1, 20);
      add_req(reb_pkg::OP_SAMPLE, cur_a, cur_b, ~down, gen_ms, pick_count());
    end
    gen_ms += $urandom_range(1, 50);
    add_req(reb_pkg::OP_SAMPLE, cur_a, cur_b, down, gen_ms, pick_count());
    t0 = gen_ms;
    // Hold times sit mostly right at the short and long thresholds.
    case ($urandom_range(0, 2))
      0: base = int'(short_ms);
      1: base = int'(long_ms);
      default: base = -1;
    endcase
    if (base < 0) begin
      hold = $urandom_range(0, long_ms + long_ms / 2 + 2);
    end else begin
      hold = base + $urandom_range(0, 3) - 1;
      if (hold < 0) hold = 0;
    end
    steps = $urandom_range(0, 3);
    for (int j = 1; j <= steps; j++) begin
      gen_ms = t0 + hold * j / (steps + 1);
      if ($urandom_range(0, 1)) begin
        if (cur_a == cur_b) cur_b = ~cur_b;
        else cur_a = ~cur_a;
        add_req(reb_pkg::OP_SAMPLE, cur_a, cur_b, down, gen_ms, pick_count());
      end else begin
        add_req(reb_pkg::OP_POLL_CANCEL, cur_a, cur_b,
                ($urandom_range(0, 7) == 0) ? ~down : down, gen_ms, pick_count());
      end
    end
    if (hold > long_ms + 1 && $urandom_range(0, 1)) begin
      add_req(reb_pkg::OP_POLL_CANCEL, cur_a, cur_b, down, t0 + long_ms + 1, pick_count());
    end
    gen_ms = t0 + hold;
    add_req(reb_pkg::OP_SAMPLE, cur_a, cur_b, ~down, gen_ms, pick_count());
    case ($urandom_range(0, 3))
      0: begin
        add_req(reb_pkg::OP_POLL_OK, cur_a, cur_b, ~down, gen_ms + 1, pick_count());
        add_req(reb_pkg::OP_POLL_CANCEL, cur_a, cur_b, ~down, gen_ms + 2, pick_count());
      end
      1: begin
        add_req(reb_pkg::OP_POLL_CANCEL, cur_a, cur_b, ~down, gen_ms + 1, pick_count());
        add_req(reb_pkg::OP_POLL_OK, cur_a, cur_b, ~down, gen_ms + 2, pick_count());
      end
      2: begin
        add_req(reb_pkg::OP_CLEAR_ENTER, cur_a, cur_b, ~down, gen_ms + 1, pick_count());
        add_req(reb_pkg::OP_POLL_OK, cur_a, cur_b, ~down, gen_ms + 2, pick_count());
      end
      default: ;
    endcase
    gen_ms += 2;
  endtask

  task automatic soft_op(input logic [2:0] op);
    add_req(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), gen_ms, pick_count());
  endtask

  task automatic gen_phase(input int n);
    int goal, r;
    goal = items_pushed + n;
    while (items_pushed < goal) begin
      r = $urandom_range(0, 99);
      gen_ms += $urandom_range(0, 5);
      if (r < 35) rotate_run();
      else if (r < 60) push_button();
      else if (r < 72) soft_op(reb_pkg::OP_READ_DELTA);
      else if (r < 78) soft_op(reb_pkg::OP_SET_COUNT);
      else if (r < 81) soft_op(reb_pkg::OP_CLEAR_COUNT);
      else if (r < 84) soft_op(reb_pkg::OP_CLEAR_ENTER);
      else if (r < 86) soft_op(reb_pkg::OP_POLL_OK);
      else if (r < 88) soft_op(reb_pkg::OP_POLL_CANCEL);
      else if (r < 90) soft_op(OP_UNUSED);
      else add_req(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                   reb_pkg::LIMIT_W'($urandom));
    end
  endtask

  initial begin
    kind_cui = 1'b0;
    act_low = 1'b0;
    wrap_on = 1'b0;
    cnt_min = '0;
    cnt_max = '0;
    short_ms = reb_pkg::SHORT_PUSH_RST;
    long_ms = reb_pkg::LONG_PUSH_RST;
    enc_count = '0;
    enc_last_read = '0;
    btn_state = reb_pkg::PRESS_IDLE;
    btn_t0 = '0;
    last_a = 1'b0;
    last_enter = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: the first sample sees edges on A and enter against the zero levels.
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd0, 16'sh7FFF);
    add_req(OP_UNUSED, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 16'sh8000);
    set_all(1'b0, 1'b0, -16'sd2, 16'sd2, 1'b0, 16'd50, 16'd1000);
    add_req(reb_pkg::OP_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd10, 16'sd0);
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b0, 1'b0, 32'd11, 16'sd0);
    add_req(reb_pkg::OP_SET_COUNT, 1'b1, 1'b0, 1'b0, 32'd12, 16'sh7FFF);
    add_req(reb_pkg::OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd13, 16'sd0);
    add_req(reb_pkg::OP_READ_DELTA, 1'b0, 1'b1, 1'b0, 32'd14, 16'sd0);
    add_req(reb_pkg::OP_SET_COUNT, 1'b0, 1'b1, 1'b0, 32'd15, 16'sh8000);
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd16, 16'sd0);
    add_req(reb_pkg::OP_READ_DELTA, 1'b1, 1'b1, 1'b0, 32'd17, 16'sd0);
    add_req(reb_pkg::OP_READ_DELTA, 1'b1, 1'b1, 1'b0, 32'd18, 16'sd0);
    add_req(reb_pkg::OP_CLEAR_COUNT, 1'b1, 1'b1, 1'b0, 32'd19, 16'sd0);
    // Short push, then a long push reported while the button is still held.
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd1000, 16'sd0);
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd1051, 16'sd0);
    add_req(reb_pkg::OP_POLL_CANCEL, 1'b1, 1'b1, 1'b0, 32'd1052, 16'sd0);
    add_req(reb_pkg::OP_POLL_OK, 1'b1, 1'b1, 1'b0, 32'd1053, 16'sd0);
    add_req(reb_pkg::OP_POLL_OK, 1'b1, 1'b1, 1'b0, 32'd1054, 16'sd0);
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd5000, 16'sd0);
    add_req(reb_pkg::OP_POLL_CANCEL, 1'b1, 1'b1, 1'b1, 32'd6001, 16'sd0);
    add_req(reb_pkg::OP_POLL_CANCEL, 1'b1, 1'b1, 1'b1, 32'd6002, 16'sd0);
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd7000, 16'sd0);
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd8000, 16'sd0);
    add_req(reb_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd9001, 16'sd0);
    add_req(reb_pkg::OP_CLEAR_ENTER, 1'b1, 1'b1, 1'b0, 32'd9002, 16'sd0);
    add_req(reb_pkg::OP_POLL_CANCEL, 1'b1, 1'b1, 1'b0, 32'd9003, 16'sd0);

    set_all(1'b0, 1'b0, -16'sd8, 16'sd8, 1'b1, 16'd50, 16'd1000);
    gen_ms = $urandom;
    gen_phase(200);
    set_all(1'b1, 1'b1, -16'sd100, 16'sd100, 1'b0, 16'd20, 16'd300);
    gen_ms = $urandom;
    gen_phase(200);
    set_all(1'b0, 1'b1, 16'h8000, 16'h7FFF, 1'b1, 16'd0, 16'd0);
    gen_ms = $urandom;
    gen_phase(200);
    // Bounds swapped, longest push times, and a timestamp about to wrap.
    set_all(1'b1, 1'b0, 16'h7FFF, 16'h8000, 1'b1, 16'hFFFF, 16'hFFFF);
    gen_ms = 32'hFFFF_FF00;
    gen_phase(200);
    set_all(1'b0, 1'b0, 16'sd5, 16'sd5, 1'b0, 16'd100, 16'd2000);
    no_idle = 1'b1;
    gen_ms = $urandom;
    gen_phase(200);
    drain();
    no_idle = 1'b0;
    set_all(1'b1, 1'b1, -16'sd3, 16'sd3, 1'b1, 16'($urandom_range(0, 200)),
            16'($urandom_range(0, 3000)));
    gen_ms = $urandom;
    gen_phase(200);
    set_all(1'b0, 1'b0, 16'h8000, 16'h7FFF, 1'b0, 16'd10, 16'd40);
    gen_ms = $urandom;
    gen_phase(200);
    set_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom),
            16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
    gen_ms = $urandom;
    gen_phase(200);

    drain();
    repeat (8) @(negedge clk_i);
    if (expected_readouts.size() != 0) begin
      $error("%0d expected results never arrived", expected_readouts.size());
      mismatches++;
    end
    $display("Sent %0d requests under %0d register settings and checked %0d results.",
             items_pushed, settings_count, results_seen);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d of %0d results checked.", results_seen, items_pushed);
    $display("== FAIL ==");
    $finish;
  end

endmodule
